[design/knv_pkg.sv]
// knv_pkg: shared types and constants of the neighbor list and vote block
// used by knv_ctrl, knv_datapath and knn_neighbor_list_vote; no dependencies
`default_nettype none

package knv_pkg;

	// fixed field widths
	localparam int DIST_W   = 32;
	localparam int CLASS_W  = 4;
	localparam int INDEX_W  = 16;
	localparam int KREG_W   = 6;
	localparam int COUNT_W  = 6;
	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 64;
	// class labels that the class field can carry
	localparam int LABELS   = 1 << CLASS_W;

	// controller states, one-hot
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_INSERT = 5'b00010,
		ST_WALK   = 5'b00100,
		ST_SCAN   = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic insert;
		logic walk;
		logic scan;
		logic emit;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic cand;
		logic last;
		logic walk_done;
		logic scan_done;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

[design/knv_ctrl.sv]
// knv_ctrl: controller state machine of the neighbor list and vote block
// depends on knv_pkg; drives knv_datapath through cmd_t and reads stat_t
`default_nettype none

module knv_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	input  wire knv_pkg::stat_t stat,
	output knv_pkg::cmd_t       cmd
);
	import knv_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// input side is open only in the idle state, between items
	assign s_tready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_INSERT;
				end
			end
			ST_INSERT: begin
				cmd.insert = stat.cand;
				state_nxt  = stat.last ? ST_WALK : ST_IDLE;
			end
			ST_WALK: begin
				if (stat.walk_done) begin
					state_nxt = ST_SCAN;
				end else begin
					cmd.walk = 1'b1;
				end
			end
			ST_SCAN: begin
				if (stat.scan_done) begin
					state_nxt = ST_EMIT;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// insertion always directly follows a load
	a_insert_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> $past(cmd.load))
		else $error("insert without a preceding load");

	// a result is never loaded over one that is still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("emit while output register busy");

	// the walk never steps past the filled entries
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk |-> !stat.walk_done)
		else $error("walk step beyond filled entries");

endmodule

`default_nettype wire

[design/knv_datapath.sv]
// knv_datapath: sorted neighbor list, vote walk, class scan and result register
// depends on knv_pkg; commanded by knv_ctrl
`default_nettype none

module knv_datapath #(
	parameter int K_MAX       = 32,
	parameter int EXTRA_SLOTS = 15,
	parameter int NUM_CLASSES = 16
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire knv_pkg::cmd_t              cmd,
	output knv_pkg::stat_t                  stat,
	input  wire [knv_pkg::KREG_W-1:0]       k_neighbors,
	input  wire [knv_pkg::S_DATA_W-1:0]     s_tdata,
	input  wire                             s_tuser,
	input  wire                             s_tlast,
	output logic                            m_tvalid,
	input  wire                             m_tready,
	output logic [knv_pkg::M_DATA_W-1:0]    m_tdata
);
	import knv_pkg::*;

	localparam int SLOTS = K_MAX + EXTRA_SLOTS;
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int NCNT  = (NUM_CLASSES < LABELS) ? NUM_CLASSES : LABELS;
	localparam int SW    = $clog2(NCNT + 1);
	localparam logic [KREG_W:0] KMAX_X = (KREG_W + 1)'(K_MAX);

	// captured item
	logic               cand_q;
	logic               last_q;
	logic [DIST_W-1:0]  in_dist_q;
	logic [CLASS_W-1:0] in_cls_q;
	logic [INDEX_W-1:0] in_idx_q;
	logic [CLASS_W-1:0] true_cls_q;
	logic [CW-1:0]      kk_q;

	// neighbor list
	logic [DIST_W-1:0]  slot_dist_q [SLOTS];
	logic [CLASS_W-1:0] slot_cls_q  [SLOTS];
	logic [INDEX_W-1:0] slot_idx_q  [SLOTS];
	logic [SLOTS-1:0]   valid_q;
	logic [CW-1:0]      count_q;

	// insertion network
	logic [SLOTS-1:0]   le;
	logic [SLOTS-1:0]   first_pos;
	logic [SLOTS-1:0]   valid_dn;
	logic [DIST_W-1:0]  dist_dn [SLOTS];
	logic [CLASS_W-1:0] cls_dn  [SLOTS];
	logic [INDEX_W-1:0] idx_dn  [SLOTS];
	logic [DIST_W-1:0]  dist_up [SLOTS];
	logic [CLASS_W-1:0] cls_up  [SLOTS];
	logic [INDEX_W-1:0] idx_up  [SLOTS];

	// vote walk and scan
	logic [CW-1:0]      walk_idx_q;
	logic [DIST_W-1:0]  ref_dist_q;
	logic [DIST_W-1:0]  near_dist_q;
	logic [INDEX_W-1:0] near_idx_q;
	logic [CW-1:0]      vote_q  [NCNT];
	logic [CW-1:0]      vote_up [NCNT];
	logic [SW-1:0]      scan_idx_q;
	logic [CW-1:0]      best_q;
	logic [CLASS_W-1:0] pred_q;
	logic               tie_q;
	logic               head_votes;
	logic [CW-1:0]      kk_nxt;

	// result fields
	logic               wrong;
	logic               filled;
	logic [INDEX_W-1:0] res_idx;
	logic [DIST_W-1:0]  res_dist;

	// status
	assign stat.cand      = cand_q;
	assign stat.last      = last_q;
	assign stat.walk_done = (walk_idx_q >= count_q);
	assign stat.scan_done = (scan_idx_q == SW'(NCNT));
	assign stat.out_free  = !m_tvalid || m_tready;

	// k clamped to 1..K_MAX
	always_comb begin
		if (k_neighbors == '0) begin
			kk_nxt = CW'(1);
		end else if ({1'b0, k_neighbors} > KMAX_X) begin
			kk_nxt = CW'(K_MAX);
		end else begin
			kk_nxt = CW'(k_neighbors);
		end
	end

	// per-slot neighbors: entry below for insertion, entry above for the walk
	for (genvar j = 0; j < SLOTS; j++) begin : g_slot
		assign le[j] = valid_q[j] && (slot_dist_q[j] <= in_dist_q);
		if (j == 0) begin : g_head
			assign first_pos[j] = 1'b1;
			assign valid_dn[j]  = 1'b1;
			assign dist_dn[j]   = in_dist_q;
			assign cls_dn[j]    = in_cls_q;
			assign idx_dn[j]    = in_idx_q;
		end else begin : g_body
			assign first_pos[j] = le[j-1];
			assign valid_dn[j]  = valid_q[j-1];
			assign dist_dn[j]   = slot_dist_q[j-1];
			assign cls_dn[j]    = slot_cls_q[j-1];
			assign idx_dn[j]    = slot_idx_q[j-1];
		end
		if (j == SLOTS - 1) begin : g_tail
			assign dist_up[j] = slot_dist_q[j];
			assign cls_up[j]  = slot_cls_q[j];
			assign idx_up[j]  = slot_idx_q[j];
		end else begin : g_mid
			assign dist_up[j] = slot_dist_q[j+1];
			assign cls_up[j]  = slot_cls_q[j+1];
			assign idx_up[j]  = slot_idx_q[j+1];
		end
	end

	// counters shift toward class zero during the scan
	for (genvar c = 0; c < NCNT; c++) begin : g_cnt
		if (c == NCNT - 1) begin : g_last
			assign vote_up[c] = '0;
		end else begin : g_next
			assign vote_up[c] = vote_q[c+1];
		end
	end

	// head entry votes if inside k or tied with entry k-1
	assign head_votes = (walk_idx_q < kk_q) || (slot_dist_q[0] == ref_dist_q);

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cand_q     <= s_tuser;
			last_q     <= s_tlast;
			in_dist_q  <= s_tdata[DIST_W-1:0];
			in_cls_q   <= s_tdata[DIST_W+CLASS_W-1:DIST_W];
			in_idx_q   <= s_tdata[DIST_W+CLASS_W+INDEX_W-1:DIST_W+CLASS_W];
			true_cls_q <= s_tdata[S_DATA_W-1:DIST_W+CLASS_W+INDEX_W];
			kk_q       <= kk_nxt;
		end
	end

	// list payload: parallel insert, or shift toward the head on a walk step
	always_ff @(posedge clk) begin
		for (int j = 0; j < SLOTS; j++) begin
			if (cmd.insert && !le[j]) begin
				slot_dist_q[j] <= first_pos[j] ? in_dist_q : dist_dn[j];
				slot_cls_q[j]  <= first_pos[j] ? in_cls_q  : cls_dn[j];
				slot_idx_q[j]  <= first_pos[j] ? in_idx_q  : idx_dn[j];
			end else if (cmd.walk) begin
				slot_dist_q[j] <= dist_up[j];
				slot_cls_q[j]  <= cls_up[j];
				slot_idx_q[j]  <= idx_up[j];
			end
		end
	end

	// list occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.emit) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.insert) begin
			for (int j = 0; j < SLOTS; j++) begin
				if (!le[j]) begin
					valid_q[j] <= first_pos[j] ? 1'b1 : valid_dn[j];
				end
			end
			if (count_q < CW'(SLOTS)) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// walk: nearest entry, k-th distance, vote counts; the counts shift during the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_idx_q <= '0;
			for (int c = 0; c < NCNT; c++) begin
				vote_q[c] <= '0;
			end
		end else if (cmd.load) begin
			walk_idx_q <= '0;
			for (int c = 0; c < NCNT; c++) begin
				vote_q[c] <= '0;
			end
		end else if (cmd.walk) begin
			walk_idx_q <= walk_idx_q + CW'(1);
			for (int c = 0; c < NCNT; c++) begin
				if (head_votes && slot_cls_q[0] == CLASS_W'(c)) begin
					vote_q[c] <= vote_q[c] + CW'(1);
				end
			end
		end else if (cmd.scan) begin
			for (int c = 0; c < NCNT; c++) begin
				vote_q[c] <= vote_up[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk) begin
			if (walk_idx_q == '0) begin
				near_dist_q <= slot_dist_q[0];
				near_idx_q  <= slot_idx_q[0];
			end
			if ((walk_idx_q + CW'(1)) == kk_q) begin
				ref_dist_q <= slot_dist_q[0];
			end
		end
	end

	// scan: lowest class with the top count, tie flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
		end else if (cmd.load) begin
			scan_idx_q <= '0;
		end else if (cmd.scan) begin
			scan_idx_q <= scan_idx_q + SW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			if (scan_idx_q == '0) begin
				best_q <= vote_q[0];
				pred_q <= '0;
				tie_q  <= 1'b0;
			end else if (vote_q[0] > best_q) begin
				best_q <= vote_q[0];
				pred_q <= CLASS_W'(scan_idx_q);
				tie_q  <= 1'b0;
			end else if (vote_q[0] == best_q) begin
				tie_q  <= 1'b1;
			end
		end
	end

	// result fields
	assign filled   = (count_q != '0);
	assign wrong    = (pred_q != true_cls_q);
	assign res_idx  = filled ? near_idx_q : '0;
	assign res_dist = filled ? near_dist_q : '0;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tdata <= {3'b000, COUNT_W'(count_q),
				wrong && filled && (near_dist_q == '0), wrong,
				res_dist, res_idx, tie_q, pred_q};
		end
	end

	// list count matches the occupancy bits
	a_count_bits: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(count_q))
		else $error("fill count disagrees with occupancy");

	// occupied entries form a prefix of the list
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_q >> 1) & ~valid_q) == '0)
		else $error("gap in neighbor list");

	// the list is empty after a result is loaded
	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (count_q == '0) && m_tvalid)
		else $error("list not cleared after result");

	// the loaded k stays within range
	a_kk_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.load) |-> (kk_q != '0) && (kk_q <= CW'(K_MAX)))
		else $error("k out of range");

endmodule

`default_nettype wire

[design/knn_neighbor_list_vote.sv]
// knn_neighbor_list_vote: top level of the k-nearest-neighbor list and vote block
// depends on knv_pkg, knv_ctrl and knv_datapath; holds the k register
//
// channel   dir  handshake            payload
// s_axis    in   s_tvalid/s_tready    s_tdata, s_tuser (candidate flag), s_tlast (last candidate)
// m_axis    out  m_tvalid/m_tready    m_tdata (one result per query)
// cfg       in   cfg_valid/cfg_ready  cfg_data (k_neighbors)
//
// every item is taken in while idle, then put in by the parallel compare-and-shift insert
// a last item then goes on to a walk over the filled list entries (head shift of the list), a class
// counter scan and a load of the output register; no new item is taken before that is done
// reset empties the list and sets k to 1; no clearing pass is needed
// a result waits in the output register; a further result waits in the emit state until taken
`default_nettype none

module knn_neighbor_list_vote #(
	parameter int K_MAX       = 32,
	parameter int EXTRA_SLOTS = 15,
	parameter int NUM_CLASSES = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	// [31:0] distance, [35:32] neighbor_class, [51:36] neighbor_index, [55:52] true_class
	input  wire [knv_pkg::S_DATA_W-1:0]  s_tdata,
	// [0] candidate_valid
	input  wire                          s_tuser,
	input  wire                          s_tlast,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	// [3:0] predicted_class, [4] vote_tie, [20:5] nearest_index, [52:21] closest_dist,
	// [53] wrong, [54] wrong_at_zero_distance, [60:55] neighbor_count, [63:61] zero
	output logic [knv_pkg::M_DATA_W-1:0] m_tdata,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [knv_pkg::KREG_W-1:0]    cfg_data
);
	import knv_pkg::*;

	cmd_t              cmd;
	stat_t             stat;
	logic [KREG_W-1:0] k_q;

	// k register, written on a cfg transfer
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= KREG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			k_q <= cfg_data;
		end
	end

	// controller
	knv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// list, vote and result datapath
	knv_datapath #(
		.K_MAX       (K_MAX),
		.EXTRA_SLOTS (EXTRA_SLOTS),
		.NUM_CLASSES (NUM_CLASSES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.k_neighbors (k_q),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

`default_nettype wire

[sim/knn_neighbor_list_vote_tb.sv]
// knn_neighbor_list_vote_tb: self-checking bench for the neighbor list and vote block
// drives candidate transfers, predicts each vote from its own sorted list model
// depends on knv_pkg and knn_neighbor_list_vote
`default_nettype none

module knn_neighbor_list_vote_tb;
	import knv_pkg::*;

	localparam int K_MAX       = 32;
	localparam int EXTRA_SLOTS = 15;
	localparam int NUM_CLASSES = 16;
	localparam int SLOTS       = K_MAX + EXTRA_SLOTS;
	// worst vote: list walk, class scan, output load, plus margin
	localparam int SETTLE      = 100;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_PHASES = 9;
	localparam int PHASE_ITEMS = 86;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_PHASE  = 3;

	// one input item
	typedef struct {
		bit               cand;
		bit [DIST_W-1:0]  distance;
		bit [CLASS_W-1:0] cls;
		bit [INDEX_W-1:0] idx;
		bit [CLASS_W-1:0] truec;
		bit               last;
	} query_item_t;

	// one result, laid out as m_tdata from the top bit down
	typedef struct packed {
		logic [2:0]         pad;
		logic [COUNT_W-1:0] cnt;
		logic               wz;
		logic               wrong;
		logic [DIST_W-1:0]  ndist;
		logic [INDEX_W-1:0] nidx;
		logic               tie;
		logic [CLASS_W-1:0] pred;
	} vote_t;

	// one row of the directed table
	typedef struct {
		int          kset;
		query_item_t it;
		bit          typed;
		vote_t       want;
	} dir_row_t;

	// receiver stall patterns
	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_COMB
	} rx_mode_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	// [31:0] distance, [35:32] neighbor_class, [51:36] neighbor_index, [55:52] true_class
	logic [S_DATA_W-1:0] s_tdata   = '0;
	// [0] candidate_valid
	logic                s_tuser   = 1'b0;
	logic                s_tlast   = 1'b0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	// [3:0] predicted_class, [4] vote_tie, [20:5] nearest_index, [52:21] closest_dist,
	// [53] wrong, [54] wrong_at_zero_distance, [60:55] neighbor_count, [63:61] zero
	logic [M_DATA_W-1:0] m_tdata;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [KREG_W-1:0]   cfg_data  = '0;

	// predictor state: sorted neighbor list and k register
	bit [DIST_W-1:0]  near_dist [SLOTS];
	bit [CLASS_W-1:0] near_cls [SLOTS];
	bit [INDEX_W-1:0] near_idx [SLOTS];
	int               near_fill = 0;
	bit [KREG_W-1:0]  k_reg = KREG_W'(1);

	vote_t       pending_votes [$];
	query_item_t candidate_feed [$];
	dir_row_t    dir_rows [$];

	int mismatches  = 0;
	int cycle_count = 0;
	int burst_left  = 10;
	int hold_req    = 0;

	knn_neighbor_list_vote #(
		.K_MAX       (K_MAX),
		.EXTRA_SLOTS (EXTRA_SLOTS),
		.NUM_CLASSES (NUM_CLASSES)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL knn_neighbor_list_vote");
			$finish;
		end
	end

	// insert after all entries of equal distance, farthest drops when full
	function automatic void list_insert(bit [DIST_W-1:0] d, bit [CLASS_W-1:0] c,
			bit [INDEX_W-1:0] x);
		int pos;
		int j;
		pos = 0;
		while (pos < near_fill && near_dist[pos] <= d)
			pos++;
		if (pos >= SLOTS)
			return;
		j = (near_fill < SLOTS) ? near_fill : SLOTS - 1;
		while (j > pos) begin
			near_dist[j] = near_dist[j-1];
			near_cls[j]  = near_cls[j-1];
			near_idx[j]  = near_idx[j-1];
			j--;
		end
		near_dist[pos] = d;
		near_cls[pos]  = c;
		near_idx[pos]  = x;
		if (near_fill < SLOTS)
			near_fill++;
	endfunction

	// vote over the first k entries plus entries tied with entry k-1, then clear the list
	function automatic vote_t tally_vote(bit [CLASS_W-1:0] truec);
		int    votes [NUM_CLASSES];
		int    kk;
		int    lim;
		int    i;
		int    best;
		int    pred;
		bit    tie;
		vote_t r;
		kk = int'(k_reg);
		if (kk < 1)
			kk = 1;
		if (kk > K_MAX)
			kk = K_MAX;
		foreach (votes[c])
			votes[c] = 0;
		lim = (kk < near_fill) ? kk : near_fill;
		for (i = 0; i < lim; i++)
			if (near_cls[i] < NUM_CLASSES)
				votes[near_cls[i]]++;
		if (near_fill >= kk) begin
			i = kk;
			while (i < near_fill && near_dist[i] == near_dist[kk-1]) begin
				if (near_cls[i] < NUM_CLASSES)
					votes[near_cls[i]]++;
				i++;
			end
		end
		pred = 0;
		best = votes[0];
		tie  = 1'b0;
		for (int c = 1; c < NUM_CLASSES; c++) begin
			if (votes[c] > best) begin
				best = votes[c];
				pred = c;
				tie  = 1'b0;
			end else if (votes[c] == best) begin
				tie = 1'b1;
			end
		end
		r       = '0;
		r.pred  = pred[CLASS_W-1:0];
		r.tie   = tie;
		r.nidx  = (near_fill != 0) ? near_idx[0] : '0;
		r.ndist = (near_fill != 0) ? near_dist[0] : '0;
		r.wrong = (pred[CLASS_W-1:0] != truec);
		r.wz    = r.wrong && near_fill != 0 && near_dist[0] == 0;
		r.cnt   = near_fill[COUNT_W-1:0];
		near_fill = 0;
		foreach (near_dist[s]) begin
			near_dist[s] = '0;
			near_cls[s]  = '0;
			near_idx[s]  = '0;
		end
		return r;
	endfunction

	function automatic vote_t mk_vote(int pred, bit tie, int nidx, bit [DIST_W-1:0] ndist,
			bit wrong, bit wz, int cnt);
		vote_t r;
		r       = '0;
		r.pred  = pred[CLASS_W-1:0];
		r.tie   = tie;
		r.nidx  = nidx[INDEX_W-1:0];
		r.ndist = ndist;
		r.wrong = wrong;
		r.wz    = wz;
		r.cnt   = cnt[COUNT_W-1:0];
		return r;
	endfunction

	function automatic void add_row(int kset, bit cand, bit [DIST_W-1:0] d, int c, int x,
			int t, bit last, bit typed, vote_t want);
		dir_row_t row;
		row.kset        = kset;
		row.it.cand     = cand;
		row.it.distance = d;
		row.it.cls      = c[CLASS_W-1:0];
		row.it.idx      = x[INDEX_W-1:0];
		row.it.truec    = t[CLASS_W-1:0];
		row.it.last     = last;
		row.typed       = typed;
		row.want        = want;
		dir_rows.push_back(row);
	endfunction

	function automatic void check_field(string fname, logic [DIST_W-1:0] want,
			logic [DIST_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0h, got %0h", fname, want, got);
		end
	endfunction

	// offer one item and wait for its transfer; the sender idles in bursts
	task automatic send_item(query_item_t it, bit typed, vote_t want, bit final_one);
		vote_t v;
		s_tdata  <= {it.truec, it.idx, it.cls, it.distance};
		s_tuser  <= it.cand;
		s_tlast  <= it.last;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		if (it.cand)
			list_insert(it.distance, it.cls, it.idx);
		if (it.last) begin
			v = tally_vote(it.truec);
			pending_votes.push_back(typed ? want : v);
		end
		burst_left--;
		if (final_one || burst_left <= 0)
			s_tvalid <= 1'b0;
		if (!final_one && burst_left <= 0)
			repeat ($urandom_range(1, 12)) @(posedge clk);
		if (burst_left <= 0)
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
				: $urandom_range(1, 16);
	endtask

	// k register write once the block has gone idle
	task automatic write_k(bit [KREG_W-1:0] v);
		while (pending_votes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		k_reg = v;
	endtask

	// one random query: candidates, some noise, then the closing item
	function automatic int queue_query();
		int          len;
		int          r;
		int          dmode;
		int          n;
		int          counted;
		bit          last_sep;
		bit [3:0]    truec;
		query_item_t it;
		r = $urandom_range(0, 99);
		if (r < 5)
			len = 0;
		else if (r < 70)
			len = $urandom_range(1, 8);
		else if (r < 90)
			len = $urandom_range(9, 30);
		else
			len = $urandom_range(40, 70);
		dmode    = $urandom_range(0, 2);
		truec    = CLASS_W'($urandom_range(0, 15));
		last_sep = (len == 0) || ($urandom_range(0, 3) == 0);
		counted  = 0;
		for (n = 0; n < len; n++) begin
			// item with neither flag, ignored by the block
			if ($urandom_range(0, 19) == 0) begin
				it.cand     = 1'b0;
				it.last     = 1'b0;
				it.distance = $urandom();
				it.cls      = CLASS_W'($urandom_range(0, 15));
				it.idx      = INDEX_W'($urandom_range(0, 65535));
				it.truec    = CLASS_W'($urandom_range(0, 15));
				candidate_feed.push_back(it);
			end
			it.cand  = 1'b1;
			it.idx   = INDEX_W'($urandom_range(0, 65535));
			it.truec = truec;
			it.last  = (n == len - 1) && !last_sep;
			case (dmode)
				0: begin
					it.distance = $urandom_range(0, 7);
					it.cls      = CLASS_W'($urandom_range(0, 3));
				end
				1: begin
					it.distance = $urandom();
					it.cls      = CLASS_W'($urandom_range(0, 15));
				end
				default: begin
					r = $urandom_range(0, 3);
					it.distance = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF
						: (r == 2) ? $urandom_range(0, 3) : $urandom();
					it.cls      = CLASS_W'($urandom_range(0, 15));
				end
			endcase
			candidate_feed.push_back(it);
			counted++;
		end
		if (last_sep) begin
			it.cand     = 1'b0;
			it.last     = 1'b1;
			it.distance = $urandom();
			it.cls      = CLASS_W'($urandom_range(0, 15));
			it.idx      = INDEX_W'($urandom_range(0, 65535));
			it.truec    = truec;
			candidate_feed.push_back(it);
			counted++;
		end
		return counted;
	endfunction

	// receiver: changing stall patterns plus a long hold-off on request
	always @(posedge clk) begin : rx_drive
		static rx_mode_t rx_mode   = RX_OPEN;
		static int       mode_left = 0;
		static int       hold_seen = 0;
		static int       hold_left = 0;
		if (mode_left == 0) begin
			rx_mode   = rx_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(20, 120);
		end else begin
			mode_left--;
		end
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default:   m_tready <= (cycle_count % 3 != 0);
			endcase
		end
	end

	// result check on every output transfer
	always @(posedge clk) begin : rx_check
		vote_t got;
		vote_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = vote_t'(m_tdata);
			if (pending_votes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %h", m_tdata);
			end else begin
				want = pending_votes.pop_front();
				check_field("predicted_class", DIST_W'(want.pred), DIST_W'(got.pred));
				check_field("vote_tie", DIST_W'(want.tie), DIST_W'(got.tie));
				check_field("nearest_index", DIST_W'(want.nidx), DIST_W'(got.nidx));
				check_field("closest_dist", want.ndist, got.ndist);
				check_field("wrong", DIST_W'(want.wrong), DIST_W'(got.wrong));
				check_field("wrong_at_zero_distance", DIST_W'(want.wz), DIST_W'(got.wz));
				check_field("neighbor_count", DIST_W'(want.cnt), DIST_W'(got.cnt));
				check_field("pad", DIST_W'(want.pad), DIST_W'(got.pad));
			end
		end
	end

	// stimulus
	initial begin : stim
		bit [KREG_W-1:0] phase_k [RAND_PHASES];
		int              counted;
		int              i;
		bit              final_one;
		query_item_t     it;

		foreach (near_dist[s]) begin
			near_dist[s] = '0;
			near_cls[s]  = '0;
			near_idx[s]  = '0;
		end

		// directed table; kset >= 0 writes k before the row
		// empty list votes class 0 with a tie, k still at its reset value
		add_row(-1, 0, 32'h0, 0, 0, 0, 1, 1, mk_vote(0, 1, 0, 32'h0, 0, 0, 0));
		add_row(-1, 0, 32'h0, 0, 0, 15, 1, 1, mk_vote(0, 1, 0, 32'h0, 1, 0, 0));
		// single candidate at the field extremes
		add_row(-1, 1, 32'h0, 15, 16'hFFFF, 15, 1, 1,
			mk_vote(15, 0, 16'hFFFF, 32'h0, 0, 0, 1));
		add_row(-1, 1, 32'h0, 3, 0, 5, 1, 1, mk_vote(3, 0, 0, 32'h0, 1, 1, 1));
		add_row(-1, 1, 32'hFFFF_FFFF, 0, 16'h1234, 0, 1, 1,
			mk_vote(0, 0, 16'h1234, 32'hFFFF_FFFF, 0, 0, 1));
		// item with neither flag leaves the list empty
		add_row(-1, 0, 32'hAAAA_5555, 10, 16'h5A5A, 6, 0, 0, '0);
		add_row(-1, 0, 32'h0, 0, 0, 0, 1, 1, mk_vote(0, 1, 0, 32'h0, 0, 0, 0));
		// k of zero acts as one; equal distances keep arrival order
		add_row(0, 1, 32'd5, 2, 10, 0, 0, 0, '0);
		add_row(-1, 1, 32'd5, 7, 11, 0, 0, 0, '0);
		add_row(-1, 1, 32'd3, 1, 12, 0, 0, 0, '0);
		add_row(-1, 1, 32'd5, 4, 13, 0, 0, 0, '0);
		add_row(-1, 0, 32'h0, 0, 0, 1, 1, 0, '0);
		// k at its maximum code, fewer entries than k
		add_row(63, 1, 32'd7, 9, 20, 0, 0, 0, '0);
		add_row(-1, 1, 32'd7, 9, 21, 0, 0, 0, '0);
		add_row(-1, 1, 32'd2, 4, 22, 9, 1, 0, '0);
		// entries tied with the k-th distance vote too
		add_row(2, 1, 32'd1, 6, 30, 0, 0, 0, '0);
		add_row(-1, 1, 32'd4, 8, 31, 0, 0, 0, '0);
		add_row(-1, 1, 32'd4, 8, 32, 0, 0, 0, '0);
		add_row(-1, 1, 32'd4, 6, 33, 0, 0, 0, '0);
		add_row(-1, 1, 32'd9, 6, 34, 8, 1, 0, '0);
		// k just above the maximum
		add_row(33, 1, 32'h8000_0000, 10, 16'h8000, 10, 1, 0, '0);

		// reset
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		for (i = 0; i < dir_rows.size(); i++) begin
			if (dir_rows[i].kset >= 0)
				write_k(dir_rows[i].kset[KREG_W-1:0]);
			final_one = (i == dir_rows.size() - 1) || (dir_rows[i+1].kset >= 0);
			send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want, final_one);
		end

		// random part, one k setting per phase
		phase_k = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd2, 6'd33, 6'd7, 6'd16, 6'd0};
		phase_k[RAND_PHASES-1] = KREG_W'($urandom_range(0, 63));
		for (int p = 0; p < RAND_PHASES; p++) begin
			write_k(phase_k[p]);
			counted = 0;
			while (counted < PHASE_ITEMS)
				counted += queue_query();
			// receiver holds off while the sender keeps offering
			if (p == HOLD_PHASE)
				hold_req <= hold_req + 1;
			while (candidate_feed.size() != 0) begin
				it = candidate_feed.pop_front();
				send_item(it, 1'b0, '0, candidate_feed.size() == 0);
			end
		end

		// drain and settle
		while (pending_votes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pending_votes.size() == 0) begin
			$display("PASS knn_neighbor_list_vote");
		end else begin
			$display("FAIL knn_neighbor_list_vote");
		end
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
design/knv_pkg.sv
design/knv_ctrl.sv
design/knv_datapath.sv
design/knn_neighbor_list_vote.sv
sim/knn_neighbor_list_vote_tb.sv
